// File: hdl/ssim_pkg.sv
package ssim_pkg;

    // Store geometry
    localparam int CAPACITY   = 16;
    localparam int POS_BITS   = 16;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int ENTRY_W    = 3 * POS_BITS;
    localparam int RIDX_W     = 4;
    localparam int STATUS_W   = 3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_MERGED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_COVERED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_READ_OK = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd4;

    // Operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // Commands from controller to datapath
    typedef struct packed {
        logic                load;
        logic                issue_scan;
        logic                issue_read;
        logic                scan_eval;
        logic                pass_restart;
        logic                copy_init;
        logic                copy_union;
        logic                copy_entry;
        logic                commit;
        logic                respond;
        logic [STATUS_W-1:0] resp_status;
    } ssim_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic is_read;
        logic rd_ok;
        logic n_zero;
        logic last;
        logic changed;
        logic covered;
        logic any;
        logic full;
        logic need_union;
        logic placed;
    } ssim_stat_t;

endpackage

// File: hdl/ssim_ram.sv
module ssim_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hdl/ssim_dp.sv
module ssim_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ssim_pkg::ssim_cmd_t             cmd,
    output ssim_pkg::ssim_stat_t            stat,
    input  logic                            op,
    input  logic [ssim_pkg::POS_BITS-1:0]   span_line,
    input  logic [ssim_pkg::POS_BITS-1:0]   span_start,
    input  logic [ssim_pkg::POS_BITS-1:0]   span_length,
    input  logic [ssim_pkg::RIDX_W-1:0]     read_index,
    output logic                            done,
    output logic [ssim_pkg::STATUS_W-1:0]   status,
    output logic [ssim_pkg::CNT_W-1:0]      span_count,
    output logic [ssim_pkg::POS_BITS-1:0]   entry_line,
    output logic [ssim_pkg::POS_BITS-1:0]   entry_start,
    output logic [ssim_pkg::POS_BITS-1:0]   entry_length
);

    localparam int P = ssim_pkg::POS_BITS;

    // Latched item
    logic                          op_reg;
    logic [P-1:0]                  line_reg;
    logic [P-1:0]                  lo0_reg;
    logic [P:0]                    hi0_reg;
    logic [ssim_pkg::RIDX_W-1:0]   rindex_reg;

    // Union being built and scan control
    logic [P-1:0]                  lo_reg;
    logic [P:0]                    hi_reg;
    logic [ssim_pkg::CNT_W-1:0]    i_reg;
    logic [ssim_pkg::CNT_W-1:0]    j_reg;
    logic [ssim_pkg::CNT_W-1:0]    count_reg;
    logic                          bank_reg;
    logic [ssim_pkg::CAPACITY-1:0] taken_reg;
    logic                          changed_reg;
    logic                          any_reg;
    logic                          covered_reg;
    logic                          placed_reg;

    // Result registers
    logic                          done_reg;
    logic [ssim_pkg::STATUS_W-1:0] status_reg;
    logic [ssim_pkg::CNT_W-1:0]    rcount_reg;
    logic [P-1:0]                  eline_reg;
    logic [P-1:0]                  estart_reg;
    logic [P-1:0]                  elen_reg;

    logic [ssim_pkg::IDX_W-1:0]    iidx;
    logic [ssim_pkg::IDX_W-1:0]    jidx;
    logic [ssim_pkg::ENTRY_W-1:0]  rdata;
    logic [ssim_pkg::ENTRY_W-1:0]  wdata;
    logic [ssim_pkg::IDX_W:0]      raddr;
    logic [ssim_pkg::IDX_W:0]      waddr;
    logic                          we;
    logic                          re;
    logic [P-1:0]                  e_line;
    logic [P-1:0]                  e_start;
    logic [P-1:0]                  e_len;
    logic [P:0]                    e_end;
    logic                          line_eq;
    logic                          hit;
    logic                          covers;
    logic                          entry_first;
    logic [P:0]                    span_len;
    logic [P-1:0]                  union_len;

    assign iidx = i_reg[ssim_pkg::IDX_W-1:0];
    assign jidx = j_reg[ssim_pkg::IDX_W-1:0];

    // Entry decode and compares
    assign e_line      = rdata[3*P-1:2*P];
    assign e_start     = rdata[2*P-1:P];
    assign e_len       = rdata[P-1:0];
    assign e_end       = {1'b0, e_start} + {1'b0, e_len};
    assign line_eq     = (e_line == line_reg);
    assign hit         = !taken_reg[iidx] && line_eq && ({1'b0, e_start} <= hi_reg)
                         && (e_end >= {1'b0, lo_reg});
    assign covers      = line_eq && (e_start <= lo0_reg) && (hi0_reg <= e_end);
    assign entry_first = (e_line < line_reg) || (line_eq && (e_start <= lo_reg));

    // Union length, saturated
    assign span_len  = hi_reg - {1'b0, lo_reg};
    assign union_len = span_len[P] ? {P{1'b1}} : span_len[P-1:0];

    // Store access: read current bank, write the other
    assign re    = cmd.issue_scan || cmd.issue_read;
    assign raddr = cmd.issue_read ? {bank_reg, ssim_pkg::IDX_W'(rindex_reg)}
                                  : {bank_reg, iidx};
    assign we    = cmd.copy_union || (cmd.copy_entry && !taken_reg[iidx]);
    assign waddr = {~bank_reg, jidx};
    assign wdata = cmd.copy_union ? {line_reg, lo_reg, union_len} : rdata;

    ssim_ram #(
        .WIDTH (ssim_pkg::ENTRY_W),
        .DEPTH (2 * ssim_pkg::CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Status to controller
    always_comb
    begin
        stat.is_read    = (op_reg == ssim_pkg::OP_READ);
        stat.rd_ok      = (ssim_pkg::CNT_W'(rindex_reg) < count_reg);
        stat.n_zero     = (count_reg == '0);
        stat.last       = ((i_reg + ssim_pkg::CNT_W'(1)) == count_reg);
        stat.changed    = changed_reg;
        stat.covered    = covered_reg;
        stat.any        = any_reg;
        stat.full       = (count_reg >= ssim_pkg::CNT_W'(ssim_pkg::CAPACITY));
        stat.need_union = !placed_reg && !taken_reg[iidx] && !entry_first;
        stat.placed     = placed_reg;
    end

    // Item latch
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= op;
            line_reg   <= span_line;
            lo0_reg    <= span_start;
            hi0_reg    <= {1'b0, span_start} + {1'b0, span_length};
            rindex_reg <= read_index;
        end
    end

    // Scan, merge and copy control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg       <= '0;
            j_reg       <= '0;
            count_reg   <= '0;
            bank_reg    <= 1'b0;
            taken_reg   <= '0;
            changed_reg <= 1'b0;
            any_reg     <= 1'b0;
            covered_reg <= 1'b0;
            placed_reg  <= 1'b0;
            lo_reg      <= '0;
            hi_reg      <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                i_reg       <= '0;
                taken_reg   <= '0;
                changed_reg <= 1'b0;
                any_reg     <= 1'b0;
                covered_reg <= 1'b0;
                lo_reg      <= span_start;
                hi_reg      <= {1'b0, span_start} + {1'b0, span_length};
            end
            if (cmd.scan_eval)
            begin
                i_reg <= i_reg + ssim_pkg::CNT_W'(1);
                if (hit)
                begin
                    taken_reg[iidx] <= 1'b1;
                    any_reg         <= 1'b1;
                    changed_reg     <= 1'b1;
                    if (e_start < lo_reg)
                    begin
                        lo_reg <= e_start;
                    end
                    if (e_end > hi_reg)
                    begin
                        hi_reg <= e_end;
                    end
                end
                if (covers)
                begin
                    covered_reg <= 1'b1;
                end
            end
            if (cmd.pass_restart)
            begin
                i_reg       <= '0;
                changed_reg <= 1'b0;
            end
            if (cmd.copy_init)
            begin
                i_reg      <= '0;
                j_reg      <= '0;
                placed_reg <= 1'b0;
            end
            if (cmd.copy_union)
            begin
                j_reg      <= j_reg + ssim_pkg::CNT_W'(1);
                placed_reg <= 1'b1;
            end
            if (cmd.copy_entry)
            begin
                i_reg <= i_reg + ssim_pkg::CNT_W'(1);
                if (!taken_reg[iidx])
                begin
                    j_reg <= j_reg + ssim_pkg::CNT_W'(1);
                end
            end
            if (cmd.commit)
            begin
                count_reg <= j_reg;
                bank_reg  <= ~bank_reg;
            end
        end
    end

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.respond;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.respond)
        begin
            status_reg <= cmd.resp_status;
            rcount_reg <= count_reg;
            if (cmd.resp_status == ssim_pkg::ST_READ_OK)
            begin
                eline_reg  <= e_line;
                estart_reg <= e_start;
                elen_reg   <= e_len;
            end
            else
            begin
                eline_reg  <= '0;
                estart_reg <= '0;
                elen_reg   <= '0;
            end
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign span_count   = rcount_reg;
    assign entry_line   = eline_reg;
    assign entry_start  = estart_reg;
    assign entry_length = elen_reg;

    // Checks
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ssim_pkg::CNT_W'(ssim_pkg::CAPACITY))
        else $error("stored count above capacity");

    a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held two cycles");

    a_write_bound: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (j_reg < ssim_pkg::CNT_W'(ssim_pkg::CAPACITY)))
        else $error("copy write beyond capacity");

    a_commit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (count_reg != '0))
        else $error("insert left the store empty");

endmodule

// File: hdl/ssim_ctrl.sv
module ssim_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    output ssim_pkg::ssim_cmd_t  cmd,
    input  ssim_pkg::ssim_stat_t stat
);

    typedef enum logic [9:0] {
        S_IDLE       = 10'b00_0000_0001,
        S_DISPATCH   = 10'b00_0000_0010,
        S_RDATA      = 10'b00_0000_0100,
        S_SCAN_ISSUE = 10'b00_0000_1000,
        S_SCAN_EVAL  = 10'b00_0001_0000,
        S_PASS_END   = 10'b00_0010_0000,
        S_COPY_ISSUE = 10'b00_0100_0000,
        S_COPY_EVAL  = 10'b00_1000_0000,
        S_TAIL       = 10'b01_0000_0000,
        S_COMMIT     = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   respond_ok_reg;
    logic   respond_ok_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            respond_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            respond_ok_reg <= respond_ok_next;
        end
    end

    assign busy = (state_reg != S_IDLE) || respond_ok_reg;

    // Sequencing of read, merge passes and copy
    always_comb
    begin
        state_next      = state_reg;
        respond_ok_next = 1'b0;
        cmd             = '0;
        cmd.resp_status = ssim_pkg::ST_MERGED;
        if (respond_ok_reg)
        begin
            cmd.respond     = 1'b1;
            cmd.resp_status = ssim_pkg::ST_MERGED;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (start && !respond_ok_reg)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.is_read)
                begin
                    if (stat.rd_ok)
                    begin
                        cmd.issue_read = 1'b1;
                        state_next     = S_RDATA;
                    end
                    else
                    begin
                        cmd.respond     = 1'b1;
                        cmd.resp_status = ssim_pkg::ST_RANGE;
                        state_next      = S_IDLE;
                    end
                end
                else if (stat.n_zero)
                begin
                    cmd.copy_init = 1'b1;
                    state_next    = S_TAIL;
                end
                else
                begin
                    state_next = S_SCAN_ISSUE;
                end
            end
            S_RDATA:
            begin
                cmd.respond     = 1'b1;
                cmd.resp_status = ssim_pkg::ST_READ_OK;
                state_next      = S_IDLE;
            end
            S_SCAN_ISSUE:
            begin
                cmd.issue_scan = 1'b1;
                state_next     = S_SCAN_EVAL;
            end
            S_SCAN_EVAL:
            begin
                cmd.scan_eval = 1'b1;
                state_next    = stat.last ? S_PASS_END : S_SCAN_ISSUE;
            end
            S_PASS_END:
            begin
                priority if (stat.covered)
                begin
                    cmd.respond     = 1'b1;
                    cmd.resp_status = ssim_pkg::ST_COVERED;
                    state_next      = S_IDLE;
                end
                else if (stat.changed)
                begin
                    cmd.pass_restart = 1'b1;
                    state_next       = S_SCAN_ISSUE;
                end
                else if (!stat.any && stat.full)
                begin
                    cmd.respond     = 1'b1;
                    cmd.resp_status = ssim_pkg::ST_FULL;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.copy_init = 1'b1;
                    state_next    = S_COPY_ISSUE;
                end
            end
            S_COPY_ISSUE:
            begin
                cmd.issue_scan = 1'b1;
                state_next     = S_COPY_EVAL;
            end
            S_COPY_EVAL:
            begin
                if (stat.need_union)
                begin
                    cmd.copy_union = 1'b1;
                end
                else
                begin
                    cmd.copy_entry = 1'b1;
                    state_next     = stat.last ? S_TAIL : S_COPY_ISSUE;
                end
            end
            S_TAIL:
            begin
                cmd.copy_union = !stat.placed;
                state_next     = S_COMMIT;
            end
            S_COMMIT:
            begin
                cmd.commit      = 1'b1;
                respond_ok_next = 1'b1;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Checks
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (state_reg == S_IDLE))
        else $error("item loaded while busy");

    a_commit_resp: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (cmd.respond && (cmd.resp_status == ssim_pkg::ST_MERGED)))
        else $error("commit not followed by merged result");

    a_union_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.copy_union |-> !stat.placed)
        else $error("union written twice");

endmodule

// File: hdl/span_set_insert_merge_unit.sv
// Sorted span set with insert-and-merge.
// Command channel: an item (op, span_line, span_start, span_length, read_index)
// is taken at a rising edge with start high and busy low. op 0 inserts the
// span, op 1 reads the stored entry at read_index.
// Result channel: done is high for one cycle with status, span_count and the
// entry fields; the receiver cannot hold it off, so results are never lost.
// busy stays high from the accepting edge until the result cycle.
// For a read, the index is checked in the dispatch state and the entry is read
// through the registered read port; an out-of-range index is answered directly
// from dispatch. An insert runs merge passes over the store, one entry at a
// time through the registered read port (an issue state, then an evaluate
// state); passes repeat while a pass joined a span, then a final pass that
// joins nothing, then a copy into the other store bank that places the union
// before the first kept entry that sorts after it, or at the tail. An insert
// into an empty store skips the passes; covered and full inserts end after
// the first pass.
// Reset clears the count, so the store reads empty; the store contents
// themselves are not cleared and need no clearing pass.
module span_set_insert_merge_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            op,
    input  logic [ssim_pkg::POS_BITS-1:0]   span_line,
    input  logic [ssim_pkg::POS_BITS-1:0]   span_start,
    input  logic [ssim_pkg::POS_BITS-1:0]   span_length,
    input  logic [ssim_pkg::RIDX_W-1:0]     read_index,
    output logic                            done,
    output logic [ssim_pkg::STATUS_W-1:0]   status,
    output logic [ssim_pkg::CNT_W-1:0]      span_count,
    output logic [ssim_pkg::POS_BITS-1:0]   entry_line,
    output logic [ssim_pkg::POS_BITS-1:0]   entry_start,
    output logic [ssim_pkg::POS_BITS-1:0]   entry_length
);

    ssim_pkg::ssim_cmd_t  cmd;
    ssim_pkg::ssim_stat_t stat;

    ssim_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    ssim_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .op           (op),
        .span_line    (span_line),
        .span_start   (span_start),
        .span_length  (span_length),
        .read_index   (read_index),
        .done         (done),
        .status       (status),
        .span_count   (span_count),
        .entry_line   (entry_line),
        .entry_start  (entry_start),
        .entry_length (entry_length)
    );

endmodule

// File: sim/span_set_insert_merge_unit_tb.sv
`timescale 1ns / 100ps

module span_set_insert_merge_unit_tb;

    // Command and result records
    typedef struct {
        logic                          op;
        logic [ssim_pkg::POS_BITS-1:0] ln;
        logic [ssim_pkg::POS_BITS-1:0] st;
        logic [ssim_pkg::POS_BITS-1:0] len;
        logic [ssim_pkg::RIDX_W-1:0]   idx;
    } span_cmd_t;

    typedef struct {
        logic [ssim_pkg::STATUS_W-1:0] status;
        logic [ssim_pkg::CNT_W-1:0]    count;
        logic [ssim_pkg::POS_BITS-1:0] e_line;
        logic [ssim_pkg::POS_BITS-1:0] e_start;
        logic [ssim_pkg::POS_BITS-1:0] e_length;
    } span_resp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic op = ssim_pkg::OP_INSERT;
    logic [ssim_pkg::POS_BITS-1:0] span_line = '0;
    logic [ssim_pkg::POS_BITS-1:0] span_start = '0;
    logic [ssim_pkg::POS_BITS-1:0] span_length = '0;
    logic [ssim_pkg::RIDX_W-1:0] read_index = '0;
    logic done;
    logic [ssim_pkg::STATUS_W-1:0] status;
    logic [ssim_pkg::CNT_W-1:0] span_count;
    logic [ssim_pkg::POS_BITS-1:0] entry_line;
    logic [ssim_pkg::POS_BITS-1:0] entry_start;
    logic [ssim_pkg::POS_BITS-1:0] entry_length;

    span_cmd_t  pending_cmds[$];
    span_resp_t expected_resps[$];
    span_resp_t accepted_resp;
    int         fail_count = 0;
    int         gap_left = 0;

    // Shadow copy of the span store
    int mdl_line[ssim_pkg::CAPACITY];
    int mdl_start[ssim_pkg::CAPACITY];
    int mdl_len[ssim_pkg::CAPACITY];
    int mdl_count = 0;

    int pool_lines[8] = '{0, 1, 2, 3, 4, 5, 6, 65535};

    span_set_insert_merge_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .op(op),
        .span_line(span_line), .span_start(span_start), .span_length(span_length),
        .read_index(read_index), .done(done), .status(status),
        .span_count(span_count), .entry_line(entry_line),
        .entry_start(entry_start), .entry_length(entry_length)
    );

    always #5 clk = ~clk;

    // Insert with merge into the shadow store; returns the status code
    function automatic logic [ssim_pkg::STATUS_W-1:0] merge_insert(int ln, int st, int len);
        bit taken[ssim_pkg::CAPACITY];
        int kl[ssim_pkg::CAPACITY];
        int ks[ssim_pkg::CAPACITY];
        int kn[ssim_pkg::CAPACITY];
        int lo;
        int hi;
        int k;
        int pos;
        int es;
        int ee;
        bit changed;
        bit any;
        lo = st;
        hi = st + len;
        any = 0;
        for (int i = 0; i < mdl_count; i++)
        begin
            if (mdl_line[i] == ln && mdl_start[i] <= lo && hi <= mdl_start[i] + mdl_len[i])
                return ssim_pkg::ST_COVERED;
        end
        for (int i = 0; i < ssim_pkg::CAPACITY; i++)
            taken[i] = 0;
        // repeat joining until the union stops growing
        do
        begin
            changed = 0;
            for (int i = 0; i < mdl_count; i++)
            begin
                es = mdl_start[i];
                ee = mdl_start[i] + mdl_len[i];
                if (!taken[i] && mdl_line[i] == ln && es <= hi && ee >= lo)
                begin
                    taken[i] = 1;
                    any = 1;
                    changed = 1;
                    if (es < lo) lo = es;
                    if (ee > hi) hi = ee;
                end
            end
        end while (changed);
        if (!any && mdl_count >= ssim_pkg::CAPACITY)
            return ssim_pkg::ST_FULL;
        k = 0;
        for (int i = 0; i < mdl_count; i++)
        begin
            if (!taken[i])
            begin
                kl[k] = mdl_line[i];
                ks[k] = mdl_start[i];
                kn[k] = mdl_len[i];
                k++;
            end
        end
        pos = 0;
        while (pos < k && (kl[pos] < ln || (kl[pos] == ln && ks[pos] <= lo)))
            pos++;
        for (int i = 0; i < pos; i++)
        begin
            mdl_line[i] = kl[i];
            mdl_start[i] = ks[i];
            mdl_len[i] = kn[i];
        end
        mdl_line[pos] = ln;
        mdl_start[pos] = lo;
        mdl_len[pos] = (hi - lo > 65535) ? 65535 : hi - lo;
        for (int i = pos; i < k; i++)
        begin
            mdl_line[i + 1] = kl[i];
            mdl_start[i + 1] = ks[i];
            mdl_len[i + 1] = kn[i];
        end
        mdl_count = k + 1;
        return ssim_pkg::ST_MERGED;
    endfunction

    // Expected result of one accepted transaction
    function automatic span_resp_t predict_span_resp(span_cmd_t c);
        span_resp_t r;
        r.e_line = '0;
        r.e_start = '0;
        r.e_length = '0;
        if (c.op == ssim_pkg::OP_INSERT)
            r.status = merge_insert(c.ln, c.st, c.len);
        else if (c.idx < mdl_count)
        begin
            r.status = ssim_pkg::ST_READ_OK;
            r.e_line = ssim_pkg::POS_BITS'(mdl_line[c.idx]);
            r.e_start = ssim_pkg::POS_BITS'(mdl_start[c.idx]);
            r.e_length = ssim_pkg::POS_BITS'(mdl_len[c.idx]);
        end
        else
            r.status = ssim_pkg::ST_RANGE;
        r.count = ssim_pkg::CNT_W'(mdl_count);
        return r;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 80);
        if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 3);
    endfunction

    task automatic push_cmd(logic o, int ln, int st, int len, int idx);
        span_cmd_t c;
        c.op = o;
        c.ln = ssim_pkg::POS_BITS'(ln);
        c.st = ssim_pkg::POS_BITS'(st);
        c.len = ssim_pkg::POS_BITS'(len);
        c.idx = ssim_pkg::RIDX_W'(idx);
        pending_cmds = {pending_cmds, c};
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        fail_count++;
    endtask

    // Driver: one transaction per accept, random gaps between
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                accepted_resp = predict_span_resp(pending_cmds.pop_front());
                expected_resps = {expected_resps, accepted_resp};
                gap_left = pick_gap();
            end
            if (!(start && busy))
            begin
                if (gap_left == 0 && pending_cmds.size() > 0 && !(start && !busy
                    && pending_cmds.size() == 0))
                begin
                    start <= 1'b1;
                    op <= pending_cmds[0].op;
                    span_line <= pending_cmds[0].ln;
                    span_start <= pending_cmds[0].st;
                    span_length <= pending_cmds[0].len;
                    read_index <= pending_cmds[0].idx;
                end
                else
                begin
                    start <= 1'b0;
                    if (gap_left > 0) gap_left--;
                end
            end
        end
    end

    // Monitor: compare each result with the oldest expectation
    always @(posedge clk)
    begin
        span_resp_t w;
        if (rst_n && done)
        begin
            if (expected_resps.size() == 0)
            begin
                report_mismatch("result with no transaction pending", 1, 0);
            end
            else
            begin
                w = expected_resps.pop_front();
                if (status !== w.status) report_mismatch("status", status, w.status);
                if (span_count !== w.count) report_mismatch("span_count", span_count, w.count);
                if (entry_line !== w.e_line)
                    report_mismatch("entry_line", entry_line, w.e_line);
                if (entry_start !== w.e_start)
                    report_mismatch("entry_start", entry_start, w.e_start);
                if (entry_length !== w.e_length)
                    report_mismatch("entry_length", entry_length, w.e_length);
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        int r;
        int ln;
        // fill the store, then hit it while full
        for (int l = 0; l < 8; l++)
        begin
            push_cmd(ssim_pkg::OP_INSERT, pool_lines[l], 100, 10, 0);
            push_cmd(ssim_pkg::OP_INSERT, pool_lines[l], 300, 10, 0);
        end
        push_cmd(ssim_pkg::OP_INSERT, 8, 0, 1, 0);
        push_cmd(ssim_pkg::OP_READ, 0, 0, 0, 15);
        push_cmd(ssim_pkg::OP_INSERT, 0, 110, 0, 0);
        push_cmd(ssim_pkg::OP_INSERT, 0, 100, 10, 0);
        push_cmd(ssim_pkg::OP_INSERT, 0, 103, 2, 0);
        push_cmd(ssim_pkg::OP_INSERT, 0, 95, 5, 0);
        push_cmd(ssim_pkg::OP_INSERT, 0, 110, 190, 0);
        push_cmd(ssim_pkg::OP_INSERT, 0, 500, 0, 0);
        push_cmd(ssim_pkg::OP_INSERT, 0, 0, 65535, 0);
        push_cmd(ssim_pkg::OP_INSERT, 65535, 65535, 65535, 0);
        push_cmd(ssim_pkg::OP_INSERT, 65535, 0, 65535, 0);
        push_cmd(ssim_pkg::OP_READ, 0, 0, 0, 0);
        push_cmd(ssim_pkg::OP_READ, 0, 0, 0, 0);
        push_cmd(ssim_pkg::OP_READ, 0, 0, 0, 1);
        push_cmd(ssim_pkg::OP_READ, 0, 0, 0, 15);
        // random part: clustered spans on few lines, sweeps, reads
        for (int n = 0; n < 1900; n++)
        begin
            r = $urandom_range(0, 99);
            ln = pool_lines[$urandom_range(0, 7)];
            if (r < 45)
                push_cmd(ssim_pkg::OP_INSERT, ln, $urandom_range(0, 400),
                         $urandom_range(1, 40), 0);
            else if (r < 55)
                push_cmd(ssim_pkg::OP_INSERT, ln, $urandom_range(0, 65535),
                         $urandom_range(1, 65535), 0);
            else if (r < 60)
                push_cmd(ssim_pkg::OP_INSERT, ln, 0, 65535, 0);
            else if (r < 64)
                push_cmd(ssim_pkg::OP_INSERT, $urandom_range(0, 65535),
                         $urandom_range(0, 65535), $urandom_range(1, 65535), 0);
            else
                push_cmd(ssim_pkg::OP_READ, $urandom_range(0, 65535),
                         $urandom_range(0, 65535), $urandom_range(0, 65535),
                         $urandom_range(0, 15));
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_cmds.size() != 0 || start)
            @(posedge clk);
        while (expected_resps.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Run limit
    initial
    begin
        #40ms;
        $display("tb: failure");
        $finish;
    end

endmodule

// File: files.f
hdl/ssim_pkg.sv
hdl/ssim_ram.sv
hdl/ssim_dp.sv
hdl/ssim_ctrl.sv
hdl/span_set_insert_merge_unit.sv
sim/span_set_insert_merge_unit_tb.sv
